>>> src/orbcam_pkg.sv
// ----------------------------------------------------------------------------
// Orbit camera package
// Shared types, fixed-point constants and helper functions for the orbit
// camera update block.
// ----------------------------------------------------------------------------
package orbcam_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int COORD_FRAC_BITS = 16;
  localparam int UNIT_FRAC_BITS  = 14;
  localparam int CORDIC_STEPS    = 16;

  localparam int PADDR_BITS = 3;

  // Register addresses, decoded on bit 2 of the byte address.
  localparam logic REG_DEFAULT_RADIUS = 1'b0;
  localparam logic REG_INITIAL_PITCH  = 1'b1;

  // Pitch is held to one sixth of a turn either way.
  localparam logic signed [17:0] PITCH_LIMIT = 18'((1 << ANGLE_BITS) / 6);

  // One unit in Q1.14 and one unit in Q16.16.
  localparam logic signed [15:0] UNIT_ONE  = 16'sd16384;
  localparam logic signed [63:0] COORD_ONE = 64'(1 << COORD_FRAC_BITS);

  // CORDIC start value, gain-compensated, Q2.30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Arc tangents of 2^-i in units of 2^32 per turn.
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef struct packed {
    logic               set_target;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [15:0] pitch_step;
    logic signed [15:0] yaw_step;
    logic signed [15:0] roll_step;
    logic signed [31:0] zoom_step;
  } item_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] look_x;
    logic signed [15:0] look_y;
    logic signed [15:0] look_z;
  } result_t;

  // Status from the CORDIC unit back to the sequencer.
  typedef struct packed {
    logic               done;
    logic signed [15:0] sin_val;
    logic signed [15:0] cos_val;
  } trig_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round a Q42 product sum half up to Q1.14 and clamp to +-1.0.
  function automatic logic signed [15:0] to_unit42(input logic signed [63:0] v);
    logic signed [63:0] s;
    logic signed [15:0] r;
    s = (v + 64'sd134217728) >>> 28;
    if (s > 64'(UNIT_ONE)) r = UNIT_ONE;
    else if (s < -64'(UNIT_ONE)) r = -UNIT_ONE;
    else r = s[15:0];
    return r;
  endfunction

endpackage

>>> src/orbit_camera_update_core.sv
// A request passes through the lower radius limit, the radius update, three CORDIC runs,
// the products on the shared multiplier, the fix-up and the result state, in that order.
// The CORDIC and the multiplier are shared, so a request is taken only in the idle state,
// and a stalled result holds off the next request.
// Reset (synchronous, active high) restores the camera state and the configuration registers.
// ----------------------------------------------------------------------------
// Orbit camera update core
// Per frame: loads the target when set_target is set, steps the angles and
// radius, forms the up and look vectors and places the eye on the orbit.
// ----------------------------------------------------------------------------
module orbit_camera_update_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  orbcam_pkg::item_t                    item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output orbcam_pkg::result_t                  result,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [orbcam_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import orbcam_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_DIV  = 7'b000_0010,
    S_RAD  = 7'b000_0100,
    S_ANG  = 7'b000_1000,
    S_MUL  = 7'b001_0000,
    S_FIX  = 7'b010_0000,
    S_OUT  = 7'b100_0000
  } state_t;

  state_t state;

  logic [29:0]        default_radius;
  logic [14:0]        initial_pitch;
  logic signed [15:0] pitch_angle;
  logic [15:0]        yaw_angle;
  logic [15:0]        roll_angle;
  logic [31:0]        orbit_radius;
  logic signed [31:0] aim_x, aim_y, aim_z;
  logic signed [31:0] eye_x, eye_y, eye_z;
  logic signed [15:0] up_x, up_y, up_z;
  logic signed [15:0] look_x, look_y, look_z;

  logic signed [31:0] zoom;
  logic [29:0]        quo;
  logic [1:0]         ang_sel;
  logic               ang_wait;
  logic [3:0]         k;
  logic               ph;
  logic signed [15:0] sy, cy, sp, cp, sr, cr;
  logic signed [32:0] t1;
  logic signed [63:0] acc;
  logic signed [48:0] prod;

  logic               cfg_wr;
  logic               accept;
  logic               cordic_start;
  logic [15:0]        cordic_angle;
  trig_t              trig;

  logic signed [31:0] tz_adj;
  logic signed [17:0] pitch_sum;
  logic signed [15:0] pitch_new;
  logic [63:0]        quo_prod;
  logic signed [33:0] rad_sum;
  logic [32:0]        five_dr;
  logic [31:0]        rad_hi;
  logic [31:0]        rad_new;
  logic signed [32:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [63:0] p64;
  logic signed [63:0] p_sh;
  logic signed [63:0] p_eye;
  logic signed [31:0] aim_sel;
  logic signed [31:0] eye_new;

  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign item_ready   = (state == S_IDLE);
  assign accept       = item_valid && item_ready;
  assign result_valid = (state == S_OUT);

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_DEFAULT_RADIUS: prdata = {2'b00, default_radius};
      REG_INITIAL_PITCH:  prdata = {17'd0, initial_pitch};
      default:            prdata = '0;
    endcase
  end

  // Target load, with the nudge off the eye.
  always_comb begin
    tz_adj = item.target_z;
    if (item.target_x == eye_x && item.target_y == eye_y && item.target_z == eye_z)
      tz_adj = sat32(64'(item.target_z) + COORD_ONE);
  end

  // Pitch step and clamp.
  always_comb begin
    pitch_sum = 18'(pitch_angle) + 18'(item.pitch_step);
    if (pitch_sum > PITCH_LIMIT) pitch_new = PITCH_LIMIT[15:0];
    else if (pitch_sum < -PITCH_LIMIT) pitch_new = -PITCH_LIMIT[15:0];
    else pitch_new = pitch_sum[15:0];
  end

  // Lower radius limit: default_radius / 10 by multiplying with the
  // reciprocal 2^35 / 10 rounded up, which is exact for 32-bit operands.
  assign quo_prod = 64'(default_radius) * 64'd3435973837;

  // Radius step and clamp to the zoom limits.
  always_comb begin
    rad_sum = $signed({2'b00, orbit_radius}) + 34'(zoom);
    five_dr = {1'b0, default_radius, 2'b00} + {3'b000, default_radius};
    rad_hi  = five_dr[32] ? 32'hFFFF_FFFF : five_dr[31:0];
    if (rad_sum < $signed({4'b0000, quo})) rad_new = {2'b00, quo};
    else if (rad_sum > $signed({2'b00, rad_hi})) rad_new = rad_hi;
    else rad_new = rad_sum[31:0];
  end

  // CORDIC operand: yaw, then pitch, then roll.
  always_comb begin
    unique case (ang_sel)
      2'd0:    cordic_angle = yaw_angle;
      2'd1:    cordic_angle = pitch_angle;
      default: cordic_angle = roll_angle;
    endcase
  end
  assign cordic_start = (state == S_ANG) && !ang_wait;

  orbcam_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (cordic_angle),
    .trig  (trig)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (k)
      4'd0:    begin mul_a = 33'(cr); mul_b = sp;     end
      4'd1:    begin mul_a = t1;      mul_b = sy;     end
      4'd2:    begin mul_a = 33'(sr); mul_b = cy;     end
      4'd3:    begin mul_a = t1;      mul_b = cy;     end
      4'd4:    begin mul_a = 33'(sr); mul_b = sy;     end
      4'd5:    begin mul_a = 33'(cr); mul_b = cp;     end
      4'd6:    begin mul_a = 33'(cp); mul_b = sy;     end
      4'd7:    begin mul_a = 33'(cp); mul_b = cy;     end
      4'd8:    begin mul_a = $signed({1'b0, orbit_radius}); mul_b = look_x; end
      4'd9:    begin mul_a = $signed({1'b0, orbit_radius}); mul_b = look_y; end
      4'd10:   begin mul_a = $signed({1'b0, orbit_radius}); mul_b = look_z; end
      default: begin mul_a = '0;      mul_b = '0;     end
    endcase
  end

  // Product post-processing for the basis entries and the eye.
  always_comb begin
    p64   = 64'(prod);
    p_sh  = p64 <<< UNIT_FRAC_BITS;
    p_eye = (p64 + 64'sd8192) >>> UNIT_FRAC_BITS;
    unique case (k)
      4'd8:    aim_sel = aim_x;
      4'd9:    aim_sel = aim_y;
      default: aim_sel = aim_z;
    endcase
    eye_new = sat32(64'(aim_sel) - p_eye);
  end

  // Sequencer and camera state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      default_radius <= 30'd655360;
      initial_pitch  <= '0;
      pitch_angle    <= '0;
      yaw_angle      <= '0;
      roll_angle     <= '0;
      orbit_radius   <= 32'd655360;
      aim_x          <= '0;
      aim_y          <= '0;
      aim_z          <= '0;
      eye_x          <= '0;
      eye_y          <= '0;
      eye_z          <= -32'sd655360;
      up_x           <= '0;
      up_y           <= UNIT_ONE;
      up_z           <= '0;
      look_x         <= '0;
      look_y         <= '0;
      look_z         <= UNIT_ONE;
      ang_wait       <= 1'b0;
      ph             <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_DEFAULT_RADIUS: begin
            default_radius <= pwdata[29:0];
            orbit_radius   <= {2'b00, pwdata[29:0]};
          end
          REG_INITIAL_PITCH: begin
            initial_pitch <= pwdata[14:0];
            pitch_angle   <= 16'($signed(pwdata[14:0]));
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.set_target) begin
              aim_x <= item.target_x;
              aim_y <= item.target_y;
              aim_z <= tz_adj;
            end
            pitch_angle <= pitch_new;
            yaw_angle   <= yaw_angle + item.yaw_step;
            roll_angle  <= roll_angle + item.roll_step;
            zoom        <= item.zoom_step;
            state       <= S_DIV;
          end
        end
        S_DIV: begin
          quo   <= {1'b0, quo_prod[63:35]};
          state <= S_RAD;
        end
        S_RAD: begin
          orbit_radius <= rad_new;
          ang_sel      <= 2'd0;
          ang_wait     <= 1'b0;
          state        <= S_ANG;
        end
        S_ANG: begin
          if (!ang_wait) begin
            ang_wait <= 1'b1;
          end else if (trig.done) begin
            ang_wait <= 1'b0;
            unique case (ang_sel)
              2'd0: begin sy <= trig.sin_val; cy <= trig.cos_val; end
              2'd1: begin
                sp <= trig.sin_val;
                cp <= trig.cos_val;
                look_y <= -trig.sin_val;
              end
              default: begin sr <= trig.sin_val; cr <= trig.cos_val; end
            endcase
            if (ang_sel == 2'd2) begin
              k     <= '0;
              ph    <= 1'b0;
              state <= S_MUL;
            end else begin
              ang_sel <= ang_sel + 2'd1;
            end
          end
        end
        S_MUL: begin
          ph <= !ph;
          if (!ph) begin
            prod <= mul_a * mul_b;
          end else begin
            unique case (k)
              4'd0:    t1 <= prod[32:0];
              4'd1:    acc <= p64;
              4'd2:    up_x <= to_unit42(acc - p_sh);
              4'd3:    acc <= p64;
              4'd4:    up_z <= to_unit42(acc + p_sh);
              4'd5:    up_y <= to_unit42(p_sh);
              4'd6:    look_x <= to_unit42(p_sh);
              4'd7:    look_z <= to_unit42(p_sh);
              4'd8:    eye_x <= eye_new;
              4'd9:    eye_y <= eye_new;
              default: eye_z <= eye_new;
            endcase
            k <= k + 4'd1;
            if (k == 4'd10) state <= S_FIX;
          end
        end
        S_FIX: begin
          // Keep the eye off the aim point.
          if (eye_x == aim_x && eye_y == aim_y && eye_z == aim_z)
            eye_z <= sat32(64'(aim_z) - COORD_ONE);
          state <= S_OUT;
        end
        S_OUT: begin
          if (result_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result view of the camera state.
  always_comb begin
    result.eye_x  = eye_x;
    result.eye_y  = eye_y;
    result.eye_z  = eye_z;
    result.aim_x  = aim_x;
    result.aim_y  = aim_y;
    result.aim_z  = aim_z;
    result.up_x   = up_x;
    result.up_y   = up_y;
    result.up_z   = up_z;
    result.look_x = look_x;
    result.look_y = look_y;
    result.look_z = look_z;
  end

endmodule

>>> src/orbcam_cordic.sv
// ----------------------------------------------------------------------------
// Orbit camera CORDIC
// Rotation-mode CORDIC that returns sine and cosine of one binary angle,
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module orbcam_cordic (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [orbcam_pkg::ANGLE_BITS-1:0]      angle,
  output orbcam_pkg::trig_t                      trig
);

  import orbcam_pkg::*;

  logic               busy;
  logic               done;
  logic               flip;
  logic [3:0]         cnt;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [32:0] z;

  logic signed [32:0] z_full;
  logic signed [32:0] z_fold;
  logic               flip_fold;
  logic signed [33:0] x_out;
  logic signed [33:0] y_out;

  // Spread the angle to 32 bits and fold it into the right half plane.
  always_comb begin
    z_full = 33'($signed({angle, {(32 - ANGLE_BITS){1'b0}}}));
    z_fold = z_full;
    flip_fold = 1'b0;
    if (z_full > 33'sd1073741824) begin
      z_fold = z_full - 33'sd2147483648;
      flip_fold = 1'b1;
    end else if (z_full < -33'sd1073741824) begin
      z_fold = z_full + 33'sd2147483648;
      flip_fold = 1'b1;
    end
  end

  // Micro-rotations, one per cycle, with shifters shared by all steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= z_fold;
        flip <= flip_fold;
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - (y >>> cnt);
          y <= y + (x >>> cnt);
          z <= z - $signed({1'b0, ATAN_TURN[cnt]});
        end else begin
          x <= x + (y >>> cnt);
          y <= y - (x >>> cnt);
          z <= z + $signed({1'b0, ATAN_TURN[cnt]});
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  function automatic logic signed [15:0] to_unit30(input logic signed [33:0] v);
    logic signed [33:0] s;
    logic signed [15:0] r;
    s = (v + 34'sd32768) >>> 16;
    if (s > 34'(UNIT_ONE)) r = UNIT_ONE;
    else if (s < -34'(UNIT_ONE)) r = -UNIT_ONE;
    else r = s[15:0];
    return r;
  endfunction

  // Undo the fold and round to Q1.14.
  assign x_out = flip ? -x : x;
  assign y_out = flip ? -y : y;
  assign trig.done    = done;
  assign trig.sin_val = to_unit30(y_out);
  assign trig.cos_val = to_unit30(x_out);

endmodule

>>> src/orbcam_checker.sv
// ----------------------------------------------------------------------------
// Orbit camera checker
// Port-level assertions on request and result sequencing.
// ----------------------------------------------------------------------------
module orbcam_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic result_valid,
  input logic result_ready
);

  // A pending result blocks new requests.
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready) else $error("request taken while result pending");

  // A result never appears in the cycle after a request.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (!result_valid && !item_ready))
    else $error("result too early");

  // A stalled result stays.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid) else $error("result dropped");

  // Reset clears the result side.
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid) else $error("result valid after reset");

endmodule

bind orbit_camera_update_core orbcam_checker u_orbcam_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready)
);
